// File: rtl/multi_voice_triangle_tone_mixer_core_defines.svh
// Assertion macros for the triangle tone mixer core.
`ifndef MULTI_VOICE_TRIANGLE_TONE_MIXER_CORE_DEFINES_SVH
`define MULTI_VOICE_TRIANGLE_TONE_MIXER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the core clock.
`define MVT_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("mixer check failed");
// Next-cycle implication, sampled on the core clock.
`define MVT_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("mixer check failed");
`else
`define MVT_ASSERT_NOW(label, cond, prop)
`define MVT_ASSERT_NEXT(label, cond, prop)
`endif

`endif

// File: rtl/mvt_pkg.sv
// Shared types and constants of the triangle tone mixer core.
package mvt_pkg;

	// Default configuration of the voice bank.
	localparam int NUM_VOICES_DEF = 16;
	localparam int PHASE_BITS_DEF = 32;

	// Fixed field widths.
	localparam int SCALE_W  = 16;
	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 5;
	localparam int VOICE_W  = 8;
	localparam int STEP_W   = 32;
	localparam int DUTY_W   = 32;
	localparam int ACTION_W = 2;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	// Triangle value width (Q1.16, signed) and its magnitude after averaging.
	localparam int TRI_W = 18;
	localparam int MAG_W = 17;

	// Register map and reset values.
	localparam logic REG_SCALE = 1'b0;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd5898;
	localparam int SAMPLE_MAX = 32767;

	// Request action codes.
	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK = 2'd0,
		ACT_STEP = 2'd1,
		ACT_GATE = 2'd2
	} action_t;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} state_t;

	// Control into the voice bank.
	typedef struct packed {
		logic start;
		logic wr_step_en;
		logic wr_gate_en;
	} bank_ctrl_t;

	// Status of a multi-cycle unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// File: rtl/mvt_voice_bank.sv
// Voice state storage and the per-voice walk that sums triangle values.
module mvt_voice_bank import mvt_pkg::*; #(
	parameter int NUM_VOICES = NUM_VOICES_DEF,
	parameter int PHASE_BITS = PHASE_BITS_DEF,
	parameter int VIDX_W     = 4,
	parameter int CNT_W      = 5,
	parameter int SUM_W      = 22
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bank_ctrl_t              ctrl,
	input  logic [VIDX_W-1:0]       wr_idx,
	input  logic [PHASE_BITS-1:0]   wr_step,
	input  logic                    wr_gate,
	output unit_stat_t              stat,
	output logic signed [SUM_W-1:0] sum,
	output logic [CNT_W-1:0]        cnt
);

	logic [PHASE_BITS-1:0]   phase_q [NUM_VOICES];
	logic [PHASE_BITS-1:0]   step_q  [NUM_VOICES];
	logic                    gate_q  [NUM_VOICES];
	logic [VIDX_W-1:0]       idx_q;
	logic                    busy_q;
	logic                    done_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;

	logic [15:0]             p16;
	logic signed [TRI_W-1:0] tri_base;
	logic signed [TRI_W-1:0] tri_val;
	logic                    active;

	// Triangle of the current voice: rising in the first half cycle, falling in the second.
	assign p16      = phase_q[idx_q][PHASE_BITS-1 -: 16];
	assign tri_base = $signed({1'b0, p16[14:0], 2'b00}) - $signed(TRI_W'(65536));
	assign tri_val  = p16[15] ? -tri_base : tri_base;
	assign active   = (step_q[idx_q] != '0) && gate_q[idx_q];

	// Storage writes and the walk, one voice per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < NUM_VOICES; v++) begin
				phase_q[v] <= '0;
				step_q[v]  <= '0;
				gate_q[v]  <= 1'b0;
			end
			idx_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.wr_step_en) begin
				step_q[wr_idx] <= wr_step;
			end
			if (ctrl.wr_gate_en) begin
				gate_q[wr_idx] <= wr_gate;
			end
			if (ctrl.start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				sum_q  <= '0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (active) begin
					cnt_q          <= cnt_q + 1'b1;
					sum_q          <= sum_q + SUM_W'(tri_val);
					phase_q[idx_q] <= phase_q[idx_q] + step_q[idx_q];
				end
				if (idx_q == VIDX_W'(NUM_VOICES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign sum       = sum_q;
	assign cnt       = cnt_q;

endmodule

// File: rtl/mvt_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module mvt_serial_div import mvt_pkg::*; #(
	parameter int DIVIDEND_W = 21,
	parameter int DIVISOR_W  = 5,
	parameter int QUOT_W     = MAG_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [QUOT_W-1:0]     quot,
	output unit_stat_t            stat
);

	localparam int STEP_CW = $clog2(DIVIDEND_W + 1);

	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [STEP_CW-1:0]    steps_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// Shift the next dividend bit into the remainder and try a subtract.
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				steps_q <= STEP_CW'(DIVIDEND_W);
			end else if (busy_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == STEP_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign quot      = quo_q[QUOT_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: rtl/mvt_serial_mul.sv
// Bit-serial shift-add multiplier that keeps the product shifted right by the scale width.
module mvt_serial_mul import mvt_pkg::*; #(
	parameter int MAG_BITS   = MAG_W,
	parameter int SCALE_BITS = SCALE_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [MAG_BITS-1:0]   mag,
	input  logic [SCALE_BITS-1:0] scale,
	output logic [MAG_BITS-1:0]   prod_hi,
	output unit_stat_t            stat
);

	localparam int STEP_CW = $clog2(SCALE_BITS + 1);

	logic [MAG_BITS-1:0]   hi_q;
	logic [MAG_BITS-1:0]   mag_q;
	logic [SCALE_BITS-1:0] scale_sr_q;
	logic [STEP_CW-1:0]    steps_q;
	logic                  busy_q;
	logic                  done_q;

	logic [MAG_BITS:0]     acc;

	// Add the multiplicand when the current scale bit is set; the low bit falls off.
	assign acc = {1'b0, hi_q} + (scale_sr_q[0] ? {1'b0, mag_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				steps_q <= STEP_CW'(SCALE_BITS);
			end else if (busy_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == STEP_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Accumulator and scale shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			hi_q       <= '0;
			mag_q      <= mag;
			scale_sr_q <= scale;
		end else if (busy_q) begin
			hi_q       <= acc[MAG_BITS:1];
			scale_sr_q <= scale_sr_q >> 1;
		end
	end

	assign prod_hi   = hi_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: rtl/multi_voice_triangle_tone_mixer_core.sv
// A set request is applied to the voice bank when it is accepted. A tick request walks
// the voice bank, divides the sum by the active count and scales the average; when no
// voice is active it goes straight from the walk to the output stage.
// Requests stall until a tick's result is loaded; a tick runs the walk (one voice a cycle), the
// bit-serial divider (one quotient bit a cycle) and the bit-serial scaler (one scale bit a cycle).
// Reset clears all phases, steps and gates, loads output_scale with 5898 and drops any result.
`include "multi_voice_triangle_tone_mixer_core_defines.svh"

module multi_voice_triangle_tone_mixer_core import mvt_pkg::*; #(
	parameter int NUM_VOICES = NUM_VOICES_DEF,
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration port.
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_W-1:0]          paddr,
	input  logic [DATA_W-1:0]          pwdata,
	output logic [DATA_W-1:0]          prdata,
	output logic                       pready,
	// Request channel.
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [ACTION_W-1:0]        action,
	input  logic [VOICE_W-1:0]         voice,
	input  logic [STEP_W-1:0]          phase_step,
	input  logic [DUTY_W-1:0]          duty,
	// Result channel.
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic [COUNT_W-1:0]         active_count
);

	localparam int VIDX_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int CNT_W     = $clog2(NUM_VOICES + 1);
	localparam int MAG_SUM_W = MAG_W + $clog2(NUM_VOICES);
	localparam int SUM_W     = MAG_SUM_W + 1;

	state_t                    state_q;
	state_t                    state_d;
	logic [SCALE_W-1:0]        scale_q;
	logic                      result_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [COUNT_W-1:0]        count_q;

	logic                      item_acc;
	logic                      voice_ok;
	bank_ctrl_t                bank_ctrl;
	unit_stat_t                bank_stat;
	unit_stat_t                div_stat;
	unit_stat_t                mul_stat;
	logic signed [SUM_W-1:0]   bank_sum;
	logic [CNT_W-1:0]          bank_cnt;
	logic                      sum_neg;
	logic [SUM_W-1:0]          sum_abs;
	logic [MAG_W-1:0]          avg_mag;
	logic [MAG_W-1:0]          prod_hi;
	logic [SAMPLE_W-2:0]       mag_sat;
	logic signed [SAMPLE_W-1:0] sample_val;
	logic [COUNT_W+CNT_W-1:0]  cnt_ext;
	logic                      div_start;
	logic                      mul_start;
	logic                      result_load;

	// Configuration register and readback.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SCALE)) begin
			scale_q <= pwdata[SCALE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_SCALE) ? DATA_W'(scale_q) : '0;

	// Request decode: set requests go straight to the bank, a tick starts the walk.
	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign voice_ok   = voice < VOICE_W'(NUM_VOICES);

	always_comb begin
		bank_ctrl = '0;
		unique case (action_t'(action))
			ACT_TICK: bank_ctrl.start      = item_acc;
			ACT_STEP: bank_ctrl.wr_step_en = item_acc && voice_ok;
			ACT_GATE: bank_ctrl.wr_gate_en = item_acc && voice_ok;
			default: ;
		endcase
	end

	mvt_voice_bank #(
		.NUM_VOICES (NUM_VOICES),
		.PHASE_BITS (PHASE_BITS),
		.VIDX_W     (VIDX_W),
		.CNT_W      (CNT_W),
		.SUM_W      (SUM_W)
	) u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (bank_ctrl),
		.wr_idx  (voice[VIDX_W-1:0]),
		.wr_step (phase_step[PHASE_BITS-1:0]),
		.wr_gate (duty != '0),
		.stat    (bank_stat),
		.sum     (bank_sum),
		.cnt     (bank_cnt)
	);

	// The average is taken on the magnitude so that it truncates toward zero.
	assign sum_neg = bank_sum[SUM_W-1];
	assign sum_abs = sum_neg ? (~$unsigned(bank_sum) + 1'b1) : $unsigned(bank_sum);

	mvt_serial_div #(
		.DIVIDEND_W (MAG_SUM_W),
		.DIVISOR_W  (CNT_W),
		.QUOT_W     (MAG_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_abs[MAG_SUM_W-1:0]),
		.divisor  (bank_cnt),
		.quot     (avg_mag),
		.stat     (div_stat)
	);

	mvt_serial_mul #(
		.MAG_BITS   (MAG_W),
		.SCALE_BITS (SCALE_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mag     (avg_mag),
		.scale   (scale_q),
		.prod_hi (prod_hi),
		.stat    (mul_stat)
	);

	// Saturate the scaled magnitude and restore the sign.
	assign mag_sat    = (prod_hi > MAG_W'(SAMPLE_MAX)) ? (SAMPLE_W-1)'(SAMPLE_MAX)
	                                                   : prod_hi[SAMPLE_W-2:0];
	assign sample_val = (bank_cnt == '0) ? '0 :
	                    sum_neg ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
	assign cnt_ext    = {{COUNT_W{1'b0}}, bank_cnt};

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and unit starts.
	always_comb begin
		state_d     = state_q;
		div_start   = 1'b0;
		mul_start   = 1'b0;
		result_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (bank_ctrl.start) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (bank_stat.done) begin
					if (bank_cnt == '0) begin
						state_d = ST_OUT;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					mul_start = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_stat.done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!result_valid_q || !result_stall) begin
					result_load = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (result_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			sample_q <= sample_val;
			count_q  <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign result_valid = result_valid_q;
	assign sample       = sample_q;
	assign active_count = count_q;

	// Checks on the sequencing of the units and on the output range.
	`MVT_ASSERT_NOW(a_walk_in_state, bank_stat.busy, state_q == ST_WALK)
	`MVT_ASSERT_NOW(a_units_apart, div_stat.busy, !mul_stat.busy && !bank_stat.busy)
	`MVT_ASSERT_NOW(a_sample_range, result_valid, sample != 16'sh8000)
	`MVT_ASSERT_NEXT(a_tick_holds, item_acc && (action == ACT_TICK), item_stall)

endmodule

// File: sim/multi_voice_triangle_tone_mixer_core_tb.sv
// Self-checking testbench for the sixteen-voice triangle tone mixer core.
module multi_voice_triangle_tone_mixer_core_tb;
	import mvt_pkg::*;

	localparam int VOICES = NUM_VOICES_DEF;
	localparam int SETTLE_CYCLES = 80;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES = 400;
	localparam longint CYCLE_LIMIT = 1000000;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [ADDR_W-1:0] SCALE_ADDR = ADDR_W'(REG_SCALE) << 2;
	localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;

	// One mixed sample as the result channel carries it.
	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic [COUNT_W-1:0]         count;
	} mix_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [ADDR_W-1:0]          paddr;
	logic [DATA_W-1:0]          pwdata;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;
	logic                       item_valid;
	logic                       item_stall;
	logic [ACTION_W-1:0]        action;
	logic [VOICE_W-1:0]         voice;
	logic [STEP_W-1:0]          phase_step;
	logic [DUTY_W-1:0]          duty;
	logic                       result_valid;
	logic                       result_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic [COUNT_W-1:0]         active_count;

	// Mirror of the voice bank and the gain register.
	logic [31:0]        tone_phase [VOICES];
	logic [31:0]        tone_step [VOICES];
	logic               tone_gate [VOICES];
	logic [SCALE_W-1:0] tone_scale;

	mix_result_t pending_mix [$];
	int          mismatch_count;
	longint      cycle_count;
	bit          sender_calm;
	bit          receiver_calm;
	bit          hold_request;
	int          hold_left;
	int          stall_left;
	int          stall_roll;

	multi_voice_triangle_tone_mixer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.voice        (voice),
		.phase_step   (phase_step),
		.duty         (duty),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sample       (sample),
		.active_count (active_count)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Run limit in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL multi_voice_triangle_tone_mixer_core");
			$finish;
		end
	end

	// Result side: random stalls, with one long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (receiver_calm) begin
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 70) begin
				result_stall <= 1'b0;
			end else if (stall_roll < 96) begin
				stall_left = $urandom_range(0, 2);
				result_stall <= 1'b1;
			end else begin
				stall_left = $urandom_range(15, 40);
				result_stall <= 1'b1;
			end
		end
	end

	// Compare every accepted sample with the oldest prediction.
	always @(posedge clk) begin : check_result
		mix_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_mix.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual sample %0d count %0d",
					$time, sample, active_count);
				mismatch_count++;
			end else begin
				want = pending_mix.pop_front();
				if (sample !== want.sample) begin
					$display("%0t: sample mismatch, expected %0d, actual %0d",
						$time, want.sample, sample);
					mismatch_count++;
				end
				if (active_count !== want.count) begin
					$display("%0t: active_count mismatch, expected %0d, actual %0d",
						$time, want.count, active_count);
					mismatch_count++;
				end
			end
		end
	end

	// Update the mirror with one accepted request and predict its sample.
	task automatic mixer_apply(input logic [ACTION_W-1:0] act, input logic [VOICE_W-1:0] v,
			input logic [STEP_W-1:0] st, input logic [DUTY_W-1:0] du);
		int sum;
		int active;
		int avg;
		int wave;
		longint scaled;
		logic [15:0] p16;
		mix_result_t r;
		sum = 0;
		active = 0;
		scaled = 0;
		case (act)
			ACT_STEP: begin
				if (v < VOICES)
					tone_step[v] = st;
			end
			ACT_GATE: begin
				if (v < VOICES)
					tone_gate[v] = (du != 0);
			end
			ACT_TICK: begin
				for (int i = 0; i < VOICES; i++) begin
					if (tone_step[i] != 0 && tone_gate[i]) begin
						active++;
						p16 = tone_phase[i][31:16];
						if (p16 < 16'd32768)
							wave = 4 * int'(p16) - 65536;
						else
							wave = 196608 - 4 * int'(p16);
						sum += wave;
						tone_phase[i] = tone_phase[i] + tone_step[i];
					end
				end
				if (active > 0) begin
					avg = sum / active;
					scaled = (longint'(avg) * longint'(tone_scale)) / 65536;
					if (scaled > SAMPLE_MAX)
						scaled = SAMPLE_MAX;
					if (scaled < -SAMPLE_MAX)
						scaled = -SAMPLE_MAX;
				end
				r.sample = SAMPLE_W'(scaled);
				r.count = COUNT_W'(active);
				pending_mix.push_back(r);
			end
			default: ;
		endcase
	endtask

	// Idle gap after a request: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (sender_calm || roll < 60)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one request, wait for its acceptance, then maybe idle.
	task automatic send_request(input logic [ACTION_W-1:0] act, input logic [VOICE_W-1:0] v,
			input logic [STEP_W-1:0] st, input logic [DUTY_W-1:0] du);
		int gap;
		item_valid <= 1'b1;
		action <= act;
		voice <= v;
		phase_step <= st;
		duty <= du;
		do @(posedge clk); while (item_stall);
		mixer_apply(act, v, st, du);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// A tick with random don't-care fields.
	task automatic send_tick();
		send_request(ACT_TICK, VOICE_W'($urandom), $urandom, $urandom);
	endtask

	// Stop offering requests.
	task automatic park_sender();
		item_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Wait for every sample, then let trailing set requests finish.
	task automatic wait_mixer_idle();
		while (pending_mix.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write: setup cycle, then access cycle.
	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == SCALE_ADDR)
			tone_scale = data[SCALE_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Read the gain register back and compare it with the mirror.
	task automatic check_scale_readback();
		logic [DATA_W-1:0] data;
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= SCALE_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		if (data[SCALE_W-1:0] !== tone_scale) begin
			$display("%0t: output_scale readback mismatch, expected %0d, actual %0d",
				$time, tone_scale, data[SCALE_W-1:0]);
			mismatch_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Load a new gain while the block is idle and confirm it.
	task automatic set_scale(input logic [SCALE_W-1:0] value);
		wait_mixer_idle();
		apb_write(SCALE_ADDR, {$urandom} & 32'hFFFF0000 | DATA_W'(value));
		check_scale_readback();
	endtask

	// Phase step of a random flavor: audible, full random or an extreme.
	function automatic logic [STEP_W-1:0] pick_step();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return $urandom_range(1, 200000000);
		if (roll < 85)
			return $urandom;
		if (roll < 90)
			return '1;
		if (roll < 95)
			return 32'h8000_0000;
		return '0;
	endfunction

	// Idle bank, closed gates, edge voice numbers and the unused action.
	task automatic test_directed_voices();
		send_tick();
		send_request(ACT_STEP, 8'd0, 32'h8000_0000, $urandom);
		send_tick();
		send_request(ACT_GATE, 8'd0, $urandom, 32'hFFFF_FFFF);
		send_tick();
		send_tick();
		send_request(ACT_STEP, 8'd15, 32'hFFFF_FFFF, $urandom);
		send_request(ACT_GATE, 8'd15, $urandom, 32'd1);
		send_tick();
		// Voice numbers past the bank and the unused action must leave the state alone.
		send_request(ACT_STEP, 8'(VOICES), 32'h1234_5678, $urandom);
		send_request(ACT_GATE, 8'd255, $urandom, 32'hFFFF_FFFF);
		send_request(ACT_UNUSED, 8'd3, $urandom, $urandom);
		send_tick();
		send_request(ACT_GATE, 8'd0, $urandom, 32'd0);
		send_tick();
		send_request(ACT_STEP, 8'd15, 32'd0, $urandom);
		send_tick();
		park_sender();
	endtask

	// Gain extremes: saturation at both rails, zero gain, smallest nonzero gain.
	task automatic test_scale_extremes();
		set_scale(16'hFFFF);
		send_request(ACT_STEP, 8'd1, 32'h8000_0000, $urandom);
		send_request(ACT_GATE, 8'd1, $urandom, $urandom | 32'h1);
		send_request(ACT_STEP, 8'd2, 32'h8000_0000, $urandom);
		send_request(ACT_GATE, 8'd2, $urandom, 32'h8000_0000);
		send_tick();
		send_tick();
		park_sender();
		set_scale(16'd0);
		send_tick();
		park_sender();
		set_scale(16'd1);
		send_tick();
		send_tick();
		park_sender();
		// A write past the register list is dropped.
		wait_mixer_idle();
		apb_write(SPARE_ADDR, $urandom);
		check_scale_readback();
		send_tick();
		park_sender();
	endtask

	// Every voice gated and stepping, so the count reaches sixteen.
	task automatic test_full_bank();
		set_scale(SCALE_RESET);
		for (int i = 0; i < VOICES; i++) begin
			send_request(ACT_STEP, VOICE_W'(i), pick_step() | 32'h1, $urandom);
			send_request(ACT_GATE, VOICE_W'(i), $urandom, $urandom | 32'h100);
		end
		repeat (4) send_tick();
		park_sender();
	endtask

	// Mostly well-formed voice setups followed by ticks, with some noise.
	task automatic test_random_mix(input int count, input logic [SCALE_W-1:0] gain,
			input bit calm);
		int sent;
		int ticks;
		logic [ACTION_W-1:0] act;
		logic [VOICE_W-1:0] v;
		logic [DUTY_W-1:0] du;
		set_scale(gain);
		sender_calm = calm;
		receiver_calm = calm;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 70) begin
				v = VOICE_W'($urandom_range(0, VOICES - 1));
				du = $urandom;
				if ($urandom_range(0, 9) == 0)
					du = '0;
				send_request(ACT_STEP, v, pick_step(), $urandom);
				send_request(ACT_GATE, v, $urandom, du);
				ticks = $urandom_range(1, 6);
				repeat (ticks) send_tick();
				sent += 2 + ticks;
			end else begin
				act = ACTION_W'($urandom_range(0, 3));
				v = ($urandom_range(0, 1) == 0) ? VOICE_W'($urandom_range(0, VOICES - 1))
					: VOICE_W'($urandom);
				du = ($urandom_range(0, 1) == 0) ? '0 : DUTY_W'($urandom);
				send_request(act, v, pick_step(), du);
				if (act != ACT_UNUSED && (act == ACT_TICK || v < VOICES))
					sent++;
			end
		end
		park_sender();
		sender_calm = 1'b0;
		receiver_calm = 1'b0;
	endtask

	// Long receiver hold-off while ticks keep coming, so the input backs up.
	task automatic test_backpressure();
		set_scale(16'd20000);
		sender_calm = 1'b1;
		hold_request = 1'b1;
		repeat (40) send_tick();
		park_sender();
		sender_calm = 1'b0;
	endtask

	// Reset, then the tests in turn, then the verdict.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		action = ACT_TICK;
		voice = '0;
		phase_step = '0;
		duty = '0;
		result_stall = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		sender_calm = 1'b0;
		receiver_calm = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		stall_left = 0;
		tone_scale = SCALE_RESET;
		for (int i = 0; i < VOICES; i++) begin
			tone_phase[i] = '0;
			tone_step[i] = '0;
			tone_gate[i] = 1'b0;
		end
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		check_scale_readback();
		test_directed_voices();
		test_scale_extremes();
		test_full_bank();
		test_random_mix(290, SCALE_RESET, 1'b0);
		test_random_mix(290, 16'hFFFF, 1'b0);
		test_random_mix(290, 16'd0, 1'b1);
		test_random_mix(290, 16'($urandom), 1'b0);
		test_backpressure();
		test_random_mix(290, 16'd1, 1'b0);

		while (pending_mix.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS multi_voice_triangle_tone_mixer_core");
		else
			$display("FAIL multi_voice_triangle_tone_mixer_core");
		$finish;
	end

endmodule
